// File: hw/rtl/ltwm_pkg.sv
`default_nettype none

package ltwm_pkg;

	localparam int TS_W       = 32;
	localparam int TOTAL_W    = 64;
	localparam int DIVIDEND_W = 64;
	localparam int DIVISOR_W  = 32;
	localparam int SCALE_W    = 20;
	localparam int PROD_W     = TS_W + SCALE_W;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
	localparam int CFG_IDX_W  = 1;

	localparam logic [SCALE_W-1:0] US_PER_SECOND = SCALE_W'(1000000);

	localparam logic [1:0] MODE_BEGIN = 2'd0;
	localparam logic [1:0] MODE_END   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_SECOND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERRUN_LIMIT     = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV1,
		ST_MUL,
		ST_DIV2
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic reload;
		logic write_out;
	} cmd_t;

	typedef struct packed {
		logic report;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/ltwm_in_if.sv
`default_nettype none

interface ltwm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] timestamp;

	modport source (output valid, output mode, output timestamp, input ready);
	modport sink (input valid, input mode, input timestamp, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ltwm_out_if.sv
`default_nettype none

interface ltwm_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] avg_us;
	logic [31:0] max_us;
	logic [31:0] sample_total;
	logic [31:0] overrun_total;

	modport source (output valid, output avg_us, output max_us, output sample_total,
		output overrun_total, input ready);
	modport sink (input valid, input avg_us, input max_us, input sample_total,
		input overrun_total, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ltwm_div.sv
`default_nettype none

module ltwm_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [ltwm_pkg::DIVIDEND_W-1:0]  dividend,
	input  wire logic [ltwm_pkg::DIVISOR_W-1:0]   divisor,
	output logic                                  busy,
	output logic [ltwm_pkg::DIVIDEND_W-1:0]       quotient
);

	logic                               busy_q;
	logic [ltwm_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [ltwm_pkg::DIVIDEND_W-1:0]    quo_q;
	logic [ltwm_pkg::DIVISOR_W-1:0]     rem_q;
	logic [ltwm_pkg::DIVISOR_W-1:0]     dvs_q;
	logic [ltwm_pkg::DIVISOR_W:0]       rem_sh;
	logic [ltwm_pkg::DIVISOR_W:0]       rem_diff;
	logic                               ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		rem_sh   = {rem_q, quo_q[ltwm_pkg::DIVIDEND_W-1]};
		ge       = rem_sh >= {1'b0, dvs_q};
		rem_diff = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= ltwm_pkg::DIV_CNT_W'(ltwm_pkg::DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ltwm_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ltwm_pkg::DIVIDEND_W-2:0], ge};
			rem_q <= ge ? rem_diff[ltwm_pkg::DIVISOR_W-1:0] : rem_sh[ltwm_pkg::DIVISOR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/ltwm_dp.sv
`default_nettype none

module ltwm_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ltwm_pkg::cmd_t                   cmd,
	output ltwm_pkg::sts_t                        sts,
	input  wire logic [1:0]                       mode,
	input  wire logic [ltwm_pkg::TS_W-1:0]        timestamp,
	input  wire logic                             cfg_we,
	input  wire logic [ltwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                      cfg_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [31:0]                           avg_us,
	output logic [31:0]                           max_us,
	output logic [31:0]                           sample_total,
	output logic [31:0]                           overrun_total
);

	localparam int PAD_W = ltwm_pkg::DIVIDEND_W - ltwm_pkg::PROD_W;

	logic [31:0]                        cps_q;
	logic [31:0]                        limit_q;
	logic [ltwm_pkg::TS_W-1:0]          start_q;
	logic [ltwm_pkg::TS_W-1:0]          wref_q;
	logic [31:0]                        max_q;
	logic [ltwm_pkg::TOTAL_W-1:0]       total_q;
	logic [31:0]                        count_q;
	logic [31:0]                        over_q;
	logic                               snap_zero_q;
	logic [31:0]                        snap_count_q;
	logic [31:0]                        snap_over_q;
	logic                               out_valid_q;
	logic [31:0]                        avg_q;
	logic [31:0]                        maxo_q;
	logic [31:0]                        samp_q;
	logic [31:0]                        ovr_q;

	logic [ltwm_pkg::TS_W-1:0]          dur;
	logic [ltwm_pkg::TS_W-1:0]          age;
	logic                               enabled;
	logic                               is_report;
	logic [ltwm_pkg::PROD_W-1:0]        prod_a;
	logic [ltwm_pkg::PROD_W-1:0]        prod_b;
	logic [ltwm_pkg::DIVIDEND_W-1:0]    dividend_a;
	logic [ltwm_pkg::DIVISOR_W-1:0]     divisor_a;
	logic                               start_a;
	logic                               busy_a;
	logic                               busy_b;
	logic [ltwm_pkg::DIVIDEND_W-1:0]    quo_a;
	logic [ltwm_pkg::DIVIDEND_W-1:0]    quo_b;

	always_comb begin
		dur       = timestamp - start_q;
		age       = timestamp - wref_q;
		enabled   = cps_q != '0;
		is_report = (mode == ltwm_pkg::MODE_END) && enabled && (age >= cps_q);
	end

	// The first pass divides the total by the sample count; the second pass scales
	// the truncated average to microseconds.
	always_comb begin
		prod_a     = ltwm_pkg::PROD_W'(quo_a[31:0]) * ltwm_pkg::PROD_W'(ltwm_pkg::US_PER_SECOND);
		prod_b     = ltwm_pkg::PROD_W'(max_q) * ltwm_pkg::PROD_W'(ltwm_pkg::US_PER_SECOND);
		start_a    = cmd.load | cmd.reload;
		dividend_a = cmd.load ? total_q : {{PAD_W{1'b0}}, prod_a};
		divisor_a  = cmd.load ? count_q : cps_q;
	end

	ltwm_div u_div_avg (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_a),
		.dividend (dividend_a),
		.divisor  (divisor_a),
		.busy     (busy_a),
		.quotient (quo_a)
	);

	ltwm_div u_div_max (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend ({{PAD_W{1'b0}}, prod_b}),
		.divisor  (cps_q),
		.busy     (busy_b),
		.quotient (quo_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cps_q   <= '0;
			limit_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ltwm_pkg::CFG_CYCLES_PER_SECOND: cps_q   <= cfg_data;
				ltwm_pkg::CFG_OVERRUN_LIMIT:     limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			wref_q  <= '0;
			max_q   <= '0;
			total_q <= '0;
			count_q <= '0;
			over_q  <= '0;
		end else if (cmd.accept) begin
			case (mode)
				ltwm_pkg::MODE_BEGIN: begin
					start_q <= timestamp;
				end
				ltwm_pkg::MODE_CLEAR: begin
					wref_q  <= timestamp;
					max_q   <= '0;
					total_q <= '0;
					count_q <= '0;
					over_q  <= '0;
				end
				ltwm_pkg::MODE_END: begin
					if (enabled) begin
						total_q <= total_q + ltwm_pkg::TOTAL_W'(dur);
						count_q <= count_q + 1'b1;
						if (dur > max_q) begin
							max_q <= dur;
						end
						if (dur >= limit_q) begin
							over_q <= over_q + 1'b1;
						end
						if (is_report) begin
							wref_q <= timestamp;
						end
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.load) begin
			max_q   <= '0;
			total_q <= '0;
			count_q <= '0;
			over_q  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			snap_zero_q  <= count_q == '0;
			snap_count_q <= count_q;
			snap_over_q  <= over_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_out) begin
			avg_q  <= snap_zero_q ? '0 : quo_a[31:0];
			maxo_q <= quo_b[31:0];
			samp_q <= snap_count_q;
			ovr_q  <= snap_over_q;
		end
	end

	always_comb begin
		sts.report   = is_report;
		sts.div_done = !busy_a && !busy_b;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign avg_us        = avg_q;
	assign max_us        = maxo_q;
	assign sample_total  = samp_q;
	assign overrun_total = ovr_q;

endmodule

`default_nettype wire

// File: hw/rtl/ltwm_ctrl.sv
`default_nettype none

module ltwm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire ltwm_pkg::sts_t   sts,
	output ltwm_pkg::cmd_t        cmd
);

	ltwm_pkg::state_t state_q;
	ltwm_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ltwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.load      = 1'b0;
		cmd.reload    = 1'b0;
		cmd.write_out = 1'b0;
		case (state_q)
			ltwm_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && sts.report) begin
					state_d = ltwm_pkg::ST_LOAD;
				end
			end
			ltwm_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ltwm_pkg::ST_DIV1;
			end
			ltwm_pkg::ST_DIV1: begin
				if (sts.div_done) begin
					state_d = ltwm_pkg::ST_MUL;
				end
			end
			ltwm_pkg::ST_MUL: begin
				cmd.reload = 1'b1;
				state_d    = ltwm_pkg::ST_DIV2;
			end
			ltwm_pkg::ST_DIV2: begin
				if (sts.div_done && sts.out_free) begin
					cmd.write_out = 1'b1;
					state_d       = ltwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ltwm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/loop_time_window_monitor.sv
// An event that closes no window is taken while the monitor is idle and the next word may follow at once.
// An event that closes a window yields its report word once two 64-step restoring divisions
// have run back to back, the first in parallel with the maximum's division.
// No event is taken until the report is written to the output register.
// Reset clears the configuration, the window statistics and all handshake state at once.
`default_nettype none

module loop_time_window_monitor (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	ltwm_in_if.sink                               events,
	ltwm_out_if.source                            reports,
	input  wire logic                             cfg_we,
	input  wire logic [ltwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                      cfg_data
);

	ltwm_pkg::cmd_t cmd;
	ltwm_pkg::sts_t sts;

	ltwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (events.valid),
		.in_ready (events.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ltwm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (events.mode),
		.timestamp     (events.timestamp),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (reports.valid),
		.out_ready     (reports.ready),
		.avg_us        (reports.avg_us),
		.max_us        (reports.max_us),
		.sample_total  (reports.sample_total),
		.overrun_total (reports.overrun_total)
	);

	a_valid_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(reports.valid) |-> $past(cmd.write_out))
		else $error("Report word appeared without a write from the controller.");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !events.ready)
		else $error("Event input ready while a report is being computed.");

	a_write_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> (sts.div_done && sts.out_free))
		else $error("Report written before the dividers finished or into a full slot.");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		logic [31:0] avg_us;
		logic [31:0] max_us;
		logic [31:0] sample_total;
		logic [31:0] overrun_total;
	} report_t;

	class loop_window_board;
		bit [31:0] cycles_per_second;
		bit [31:0] overrun_limit;
		bit [31:0] start_stamp;
		bit [31:0] window_ref;
		bit [31:0] max_cycles;
		bit [63:0] total_cycles;
		bit [31:0] sample_count;
		bit [31:0] overrun_count;
		report_t pending_reports[$];
		int errors;
		int reports_seen;

		function void restart_window(bit [31:0] stamp);
			max_cycles = 0;
			total_cycles = 0;
			sample_count = 0;
			overrun_count = 0;
			window_ref = stamp;
		endfunction

		function new();
			cycles_per_second = 0;
			overrun_limit = 0;
			start_stamp = 0;
			restart_window(0);
			errors = 0;
			reports_seen = 0;
		endfunction

		function bit [31:0] to_microseconds(bit [31:0] cycles);
			bit [63:0] scaled;
			scaled = {32'd0, cycles} * 64'd1000000;
			return 32'(scaled / {32'd0, cycles_per_second});
		endfunction

		function void note_event(logic [1:0] mode, logic [31:0] stamp);
			bit [31:0] duration;
			report_t expected;
			case (mode)
				ltwm_pkg::MODE_BEGIN: start_stamp = stamp;
				ltwm_pkg::MODE_CLEAR: restart_window(stamp);
				ltwm_pkg::MODE_END: begin
					if (cycles_per_second != 0) begin
						duration = stamp - start_stamp;
						total_cycles += {32'd0, duration};
						sample_count++;
						if (duration > max_cycles)
							max_cycles = duration;
						if (duration >= overrun_limit)
							overrun_count++;
						if (32'(stamp - window_ref) >= cycles_per_second) begin
							expected.avg_us = 0;
							if (sample_count != 0)
								expected.avg_us = to_microseconds(
									32'(total_cycles / {32'd0, sample_count}));
							expected.max_us = to_microseconds(max_cycles);
							expected.sample_total = sample_count;
							expected.overrun_total = overrun_count;
							pending_reports.push_back(expected);
							restart_window(stamp);
						end
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_report(report_t got);
			report_t want;
			reports_seen++;
			if (pending_reports.size() == 0) begin
				report($sformatf("report word %0d arrived with none expected", reports_seen));
			end else begin
				want = pending_reports.pop_front();
				if (got.avg_us !== want.avg_us)
					report($sformatf("word %0d avg_us %h, expected %h",
						reports_seen, got.avg_us, want.avg_us));
				if (got.max_us !== want.max_us)
					report($sformatf("word %0d max_us %h, expected %h",
						reports_seen, got.max_us, want.max_us));
				if (got.sample_total !== want.sample_total)
					report($sformatf("word %0d sample_total %h, expected %h",
						reports_seen, got.sample_total, want.sample_total));
				if (got.overrun_total !== want.overrun_total)
					report($sformatf("word %0d overrun_total %h, expected %h",
						reports_seen, got.overrun_total, want.overrun_total));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ltwm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	ltwm_in_if ev_if();
	ltwm_out_if rep_if();

	loop_window_board board;
	int holdoff_cycles = 0;
	int holdoff_request = 0;
	bit steady = 0;

	loop_time_window_monitor uut (
		.clk(clk),
		.arst_n(arst_n),
		.events(ev_if),
		.reports(rep_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 3);
		else if (r < 19)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int stall;
		stall = 0;
		rep_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holdoff_cycles > 0) begin
				rep_if.ready <= 1'b0;
				holdoff_cycles--;
			end else if (stall > 0) begin
				rep_if.ready <= 1'b0;
				stall--;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				rep_if.ready <= 1'b0;
				stall = pick_gap() - 1;
			end else begin
				rep_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rep_if.valid && rep_if.ready)
			board.check_report({rep_if.avg_us, rep_if.max_us, rep_if.sample_total,
				rep_if.overrun_total});
	end

	task automatic send_event(logic [1:0] mode, logic [31:0] stamp);
		int gap;
		gap = (steady || $urandom_range(0, 2) == 0) ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			ev_if.valid <= 1'b0;
		end
		@(negedge clk);
		ev_if.valid <= 1'b1;
		ev_if.mode <= mode;
		ev_if.timestamp <= stamp;
		do
			@(posedge clk);
		while (!ev_if.ready);
		board.note_event(mode, stamp);
	endtask

	task automatic drain();
		@(negedge clk);
		ev_if.valid <= 1'b0;
		while (board.pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [ltwm_pkg::CFG_IDX_W-1:0] index, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(logic [31:0] cps, logic [31:0] limit);
		drain();
		write_reg(ltwm_pkg::CFG_CYCLES_PER_SECOND, cps);
		write_reg(ltwm_pkg::CFG_OVERRUN_LIMIT, limit);
		board.cycles_per_second = cps;
		board.overrun_limit = limit;
	endtask

	function automatic logic [31:0] pick_duration();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return board.overrun_limit;
			1: return board.overrun_limit - 1;
			2: return $urandom;
			3, 4, 5, 6: return $urandom_range(board.overrun_limit);
			default: return board.overrun_limit + $urandom_range(0, 1000);
		endcase
	endfunction

	task automatic run_traffic(int count, logic [31:0] cps, logic [31:0] limit, bit mid_pause);
		int sent;
		int r;
		bit paused;
		logic [31:0] now;
		logic [31:0] step;
		sent = 0;
		paused = 0;
		now = $urandom;
		set_config(cps, limit);
		holdoff_cycles = holdoff_request;
		holdoff_request = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				send_event(ltwm_pkg::MODE_BEGIN, now);
				now += pick_duration();
				send_event(ltwm_pkg::MODE_END, now);
				step = (cps == 0) ? $urandom : cps / $urandom_range(1, 8);
				now += step + $urandom_range(0, 3);
				sent += 2;
			end else if (r < 75) begin
				send_event(ltwm_pkg::MODE_CLEAR, now);
				sent++;
			end else if (r < 80) begin
				send_event(MODE_UNUSED, $urandom);
			end else if (r < 90) begin
				send_event(ltwm_pkg::MODE_END, now + pick_duration());
				sent++;
			end else begin
				send_event(2'($urandom_range(0, 2)), $urandom);
				sent++;
			end
			if (mid_pause && !paused && sent >= count / 2) begin
				paused = 1;
				drain();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ev_if.valid = 1'b0;
		ev_if.mode = ltwm_pkg::MODE_BEGIN;
		ev_if.timestamp = '0;
		board = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Measurement is off after reset, yet a begin still latches its stamp.
		send_event(ltwm_pkg::MODE_END, 32'h0000_0010);
		send_event(ltwm_pkg::MODE_BEGIN, 32'h0000_0005);

		set_config(32'd1000, 32'd100);
		send_event(MODE_UNUSED, 32'hFFFF_FFFF);
		send_event(ltwm_pkg::MODE_END, 32'h0000_0032);
		send_event(ltwm_pkg::MODE_CLEAR, 32'hFFFF_FF00);
		send_event(ltwm_pkg::MODE_BEGIN, 32'hFFFF_FFF0);
		send_event(ltwm_pkg::MODE_END, 32'h0000_0050);
		send_event(ltwm_pkg::MODE_END, 32'h0000_0054);
		send_event(ltwm_pkg::MODE_END, 32'h0000_02E8);
		send_event(ltwm_pkg::MODE_BEGIN, 32'h0000_0000);
		send_event(ltwm_pkg::MODE_END, 32'hFFFF_FFFF);
		send_event(MODE_UNUSED, 32'h0000_0000);

		set_config(32'd1, 32'd0);
		send_event(ltwm_pkg::MODE_BEGIN, 32'h0000_0007);
		send_event(ltwm_pkg::MODE_END, 32'h0000_0007);
		send_event(ltwm_pkg::MODE_END, 32'h8000_0000);

		// A window of the full counter range closes only at a distance of all ones.
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(ltwm_pkg::MODE_CLEAR, 32'h1234_5678);
		send_event(ltwm_pkg::MODE_BEGIN, 32'h1234_5678);
		send_event(ltwm_pkg::MODE_END, 32'h1234_5677);
		send_event(ltwm_pkg::MODE_END, 32'h1234_5676);

		run_traffic(150, 32'd1000, 32'd300, 1'b1);

		// The receiver stalls for a long stretch while most ends close a window.
		holdoff_request = 600;
		run_traffic(60, 32'd1, 32'd0, 1'b0);

		run_traffic(120, 32'd50000, 32'hFFFF_FFFF, 1'b0);
		run_traffic(100, $urandom, $urandom, 1'b0);
		steady = 1;
		run_traffic(70, 32'd7, 32'd3, 1'b0);
		steady = 0;
		run_traffic(60, 32'hFFFF_FFFF, 32'd1000, 1'b0);
		run_traffic(40, 32'd0, 32'd0, 1'b0);

		drain();
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
